FILE: hw/rtl/edu_pkg.sv
// edu_pkg: shared types and constants for the Euclidean distance unit.
// No dependencies.
package edu_pkg;

  // Dimension count register (number of axes in the distance).
  localparam int DIM_COUNT_W = 3;
  typedef logic [DIM_COUNT_W-1:0] dim_count_t;

  localparam dim_count_t DIM_COUNT_RESET = 3'd4;
  // Smallest counts that bring in the z and w axes; below 2 acts as 2, above 4 as 4.
  localparam dim_count_t DIM_USE_Z = 3'd3;
  localparam dim_count_t DIM_USE_W = 3'd4;

endpackage

FILE: hw/rtl/euclidean_distance_unit.sv
// euclidean_distance_unit: floor(sqrt(sum of squared differences over the selected axes)).
// Pipeline: difference, square and two adder-tree stages, then one root stage per result bit.
// Throughput: one transfer per cycle while the skid is empty; depth set by the root stages.
// Critical stage: a (COORD_WIDTH+1)-bit square or a 2*COORD_WIDTH+2 bit compare/sub.
// Reset (rst_n low, synchronous): pipeline and skid empty, dimension count 4.
// Depends on edu_pkg.
module euclidean_distance_unit #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_write_en,
  input  edu_pkg::dim_count_t           cfg_write_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_a_w,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_w,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [COORD_WIDTH:0]   out_distance
);

  // Widths. |a-b| < 2^CW, so each square < 2^(2CW), the sum of four
  // < 2^(2CW+2), and the root fits in CW+1 bits.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int PAIR_W = SQ_W + 1;
  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int RAD_W  = 2 * ROOT_W;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  edu_pkg::dim_count_t dim_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= edu_pkg::DIM_COUNT_RESET;
    end else if (cfg_write_en) begin
      dim_count_r <= cfg_write_data;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: the whole pipe advances unless the skid register holds
  // a result. A stalled result at the last stage moves into the skid, so
  // the pipe keeps one free slot and in_ready comes straight from a flop.
  // ---------------------------------------------------------------------
  logic              skid_valid_r;
  logic [ROOT_W-1:0] skid_data_r;
  logic              adv;

  assign adv      = !skid_valid_r;
  assign in_ready = adv;

  // ---------------------------------------------------------------------
  // Stage 1: per-axis differences, axis selects taken with the item
  // ---------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] a_in [4];
  logic signed [COORD_WIDTH-1:0] b_in [4];

  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign a_in[3] = in_a_w;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;
  assign b_in[3] = in_b_w;

  logic                     v1_r;
  logic signed [DIFF_W-1:0] diff_r [4];
  logic                     use_z_r;
  logic                     use_w_r;
  logic signed [DIFF_W-1:0] diff_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff_nxt[i] = DIFF_W'(a_in[i]) - DIFF_W'(b_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r  <= diff_nxt;
      use_z_r <= (dim_count_r >= edu_pkg::DIM_USE_Z);
      use_w_r <= (dim_count_r >= edu_pkg::DIM_USE_W);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares, unused axes forced to zero
  // ---------------------------------------------------------------------
  logic                     v2_r;
  logic        [SQ_W-1:0]   sq_r [4];
  logic signed [2*DIFF_W-1:0] prod [4];
  logic        [SQ_W-1:0]   sq_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = diff_r[i] * diff_r[i];
    end
    sq_nxt[0] = prod[0][SQ_W-1:0];
    sq_nxt[1] = prod[1][SQ_W-1:0];
    sq_nxt[2] = use_z_r ? prod[2][SQ_W-1:0] : '0;
    sq_nxt[3] = use_w_r ? prod[3][SQ_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 and 4: adder tree
  // ---------------------------------------------------------------------
  logic              v3_r;
  logic [PAIR_W-1:0] pair0_r;
  logic [PAIR_W-1:0] pair1_r;
  logic              v4_r;
  logic [RAD_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pair0_r <= PAIR_W'(sq_r[0]) + PAIR_W'(sq_r[1]);
      pair1_r <= PAIR_W'(sq_r[2]) + PAIR_W'(sq_r[3]);
      sum_r   <= RAD_W'(pair0_r) + RAD_W'(pair1_r);
    end
  end

  // ---------------------------------------------------------------------
  // Root stages: one result bit per stage, MSB first. rem holds n - q^2;
  // bit k is set when rem >= (q << (k+1)) + 4^k.
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] rt_vld_r;
  logic [ROOT_W-1:0] rt_q_r   [ROOT_W];
  logic [RAD_W-1:0]  rt_rem_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    localparam int K = ROOT_W - 1 - g;

    logic              vld_in;
    logic [ROOT_W-1:0] q_in;
    logic [RAD_W-1:0]  rem_in;
    logic [RAD_W-1:0]  trial;
    logic              take;
    logic [ROOT_W-1:0] q_nxt;
    logic [RAD_W-1:0]  rem_nxt;

    if (g == 0) begin : g_first
      assign vld_in = v4_r;
      assign q_in   = '0;
      assign rem_in = sum_r;
    end else begin : g_next
      assign vld_in = rt_vld_r[g-1];
      assign q_in   = rt_q_r[g-1];
      assign rem_in = rt_rem_r[g-1];
    end

    always_comb begin
      trial   = (RAD_W'(q_in) << (K + 1)) | (RAD_W'(1) << (2 * K));
      take    = (rem_in >= trial);
      rem_nxt = take ? (rem_in - trial) : rem_in;
      q_nxt   = take ? (q_in | (ROOT_W'(1) << K)) : q_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[g] <= 1'b0;
      end else if (adv) begin
        rt_vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_q_r[g]   <= q_nxt;
        rt_rem_r[g] <= rem_nxt;
      end
    end
  end

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output and skid
  // ---------------------------------------------------------------------
  logic last_valid;
  logic skid_valid_nxt;

  assign last_valid   = rt_vld_r[ROOT_W-1];
  assign out_valid    = skid_valid_r || last_valid;
  assign out_distance = skid_valid_r ? skid_data_r : rt_q_r[ROOT_W-1];

  always_comb begin
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (last_valid && !out_ready) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_data_r <= rt_q_r[ROOT_W-1];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A held result in the skid is not overwritten until taken.
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_data_r)))
    else $error("skid result lost or changed while stalled");

  // While the skid is full the pipe is frozen.
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> ($stable(rt_vld_r) && $stable(v4_r) && $stable(v1_r)))
    else $error("pipeline moved while skid held a result");

  // Final remainder n - q^2 never exceeds 2q, so q is the floor root.
  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    last_valid |-> (rt_rem_r[ROOT_W-1] <= {rt_q_r[ROOT_W-1], 1'b0}))
    else $error("square root remainder out of range");

  // A distance cannot reach 2^(COORD_WIDTH+1) - 1.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance != {ROOT_W{1'b1}}))
    else $error("distance above largest possible value");

endmodule
